>>> src/vmlc_pkg.sv
// Shared constants and control types for the max-length constraint pipeline.
`default_nettype none
package vmlc_pkg;
  localparam int MASS_W    = 24;
  localparam int LIM_W     = 52;
  localparam int D2_W      = 63;
  localparam int FACT_BITS = 30;
  localparam int WGT_BITS  = 31;
  localparam logic [D2_W-1:0] D2_CAP = D2_W'(64'd1 << 62);

  typedef struct packed {
    logic valid;
    logic apply;
    logic den_zero;
  } ctl_t;

  typedef struct packed {
    logic valid;
    logic changed;
  } res_t;
endpackage
`default_nettype wire

>>> src/vmlc_axis.sv
// One axis of the correction: factor scale, mass split, rounding and saturation.
`default_nettype none
module vmlc_axis #(
  parameter int POS_WIDTH = 24
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  vmlc_pkg::ctl_t                      ctl,
  input  logic signed [POS_WIDTH:0]           d,
  input  logic signed [POS_WIDTH-1:0]         a,
  input  logic signed [POS_WIDTH-1:0]         b,
  input  logic [vmlc_pkg::FACT_BITS-1:0]      q,
  input  logic [vmlc_pkg::WGT_BITS:0]         w_a,
  output vmlc_pkg::res_t                      res,
  output logic signed [POS_WIDTH-1:0]         new_a,
  output logic signed [POS_WIDTH-1:0]         new_b
);
  import vmlc_pkg::*;

  localparam int P   = POS_WIDTH;
  localparam int PW  = P + 1 + 32;
  localparam int SDW = 34;
  localparam int MW  = SDW + 33;
  localparam int SW  = P + 2;
  localparam logic signed [PW-1:0] RND_A = PW'(1) <<< (P - 3);
  localparam logic signed [MW-1:0] RND_B = MW'(1) <<< (62 - P);
  localparam logic signed [SW-1:0] HI = SW'((64'sd1 <<< (P - 1)) - 1);
  localparam logic signed [SW-1:0] LO = SW'(-(64'sd1 <<< (P - 1)));

  // stage A: factor times difference
  ctl_t ca_r, cb_r, cc_r;
  logic signed [31:0] f_nxt;
  logic signed [PW-1:0] prod_r;
  logic [WGT_BITS:0] wa_a_r, wb_a_r, wa_b_r, wb_b_r;
  logic signed [P-1:0] a_a_r, b_a_r, a_b_r, b_b_r, a_c_r, b_c_r;

  assign f_nxt = ctl.den_zero ? 32'sd0
               : ($signed({2'b00, q}) - 32'sd536870912);

  // stage B: round to the scaled difference
  logic signed [PW-1:0] sd_full;
  logic signed [SDW-1:0] sd_r;
  assign sd_full = (prod_r + RND_A) >>> (P - 2);

  // stage C: split by mass weight
  logic signed [MW-1:0] ma_r, mb_r;

  // stage D: round, add, saturate
  logic signed [MW-1:0] ma_sh, mb_sh;
  logic signed [SW-1:0] sa, sb;
  logic signed [P-1:0] na_nxt, nb_nxt;
  assign ma_sh = (ma_r + RND_B) >>> (63 - P);
  assign mb_sh = (mb_r + RND_B) >>> (63 - P);
  assign sa = SW'(a_c_r) + SW'(ma_sh);
  assign sb = SW'(b_c_r) - SW'(mb_sh);

  always_comb begin
    if (!cc_r.apply) begin
      na_nxt = a_c_r;
      nb_nxt = b_c_r;
    end else begin
      na_nxt = (sa > HI) ? P'(HI) : (sa < LO) ? P'(LO) : P'(sa);
      nb_nxt = (sb > HI) ? P'(HI) : (sb < LO) ? P'(LO) : P'(sb);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ca_r <= '0;
      cb_r <= '0;
      cc_r <= '0;
      res  <= '0;
    end else begin
      ca_r <= ctl;
      cb_r <= ca_r;
      cc_r <= cb_r;
      res  <= '{valid: cc_r.valid, changed: cc_r.apply};
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= PW'(d) * PW'(f_nxt);
    wa_a_r <= w_a;
    wb_a_r <= (WGT_BITS+1)'(33'd1 << WGT_BITS) - w_a;
    a_a_r  <= a;
    b_a_r  <= b;
    sd_r   <= SDW'(sd_full);
    wa_b_r <= wa_a_r;
    wb_b_r <= wb_a_r;
    a_b_r  <= a_a_r;
    b_b_r  <= b_a_r;
    ma_r   <= MW'(sd_r) * MW'($signed({1'b0, wa_b_r}));
    mb_r   <= MW'(sd_r) * MW'($signed({1'b0, wb_b_r}));
    a_c_r  <= a_b_r;
    b_c_r  <= b_b_r;
    new_a  <= na_nxt;
    new_b  <= nb_nxt;
  end
endmodule
`default_nettype wire

>>> src/verlet_max_length_constraint.sv
// Top level of the pipelined max-length distance constraint.
// Latency: 39 register stages from start to out_valid.
// Throughput: one beat per clock; busy is always low and out_valid is a strobe.
// Depth is set by the two bit-per-stage dividers (31 stages) plus eight
// stages of difference, square, sum and the per-axis multiply/round chain.
// Reset (rst_n low, synchronous) clears every valid bit; payload is not reset.
`default_nettype none
module verlet_max_length_constraint #(
  parameter int POS_WIDTH = 24
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  output logic                               busy,
  input  logic signed [POS_WIDTH-1:0]        in_a_x,
  input  logic signed [POS_WIDTH-1:0]        in_a_y,
  input  logic signed [POS_WIDTH-1:0]        in_a_z,
  input  logic signed [POS_WIDTH-1:0]        in_b_x,
  input  logic signed [POS_WIDTH-1:0]        in_b_y,
  input  logic signed [POS_WIDTH-1:0]        in_b_z,
  input  logic [vmlc_pkg::MASS_W-1:0]        in_inv_mass_a,
  input  logic [vmlc_pkg::MASS_W-1:0]        in_inv_mass_b,
  input  logic [vmlc_pkg::LIM_W-1:0]         in_max_len_sq,
  output logic                               out_valid,
  output logic signed [POS_WIDTH-1:0]        out_new_a_x,
  output logic signed [POS_WIDTH-1:0]        out_new_a_y,
  output logic signed [POS_WIDTH-1:0]        out_new_a_z,
  output logic signed [POS_WIDTH-1:0]        out_new_b_x,
  output logic signed [POS_WIDTH-1:0]        out_new_b_y,
  output logic signed [POS_WIDTH-1:0]        out_new_b_z,
  output logic                               out_changed
);
  import vmlc_pkg::*;

  localparam int P    = POS_WIDTH;
  localparam int DW   = P + 1;
  localparam int NSTG = WGT_BITS;
  localparam int WRW  = MASS_W + 1;

  // The pipeline never stalls: take a beat every cycle.
  assign busy = 1'b0;

  logic signed [P-1:0] ain [3];
  logic signed [P-1:0] bin [3];
  assign ain[0] = in_a_x;
  assign ain[1] = in_a_y;
  assign ain[2] = in_a_z;
  assign bin[0] = in_b_x;
  assign bin[1] = in_b_y;
  assign bin[2] = in_b_z;

  // Stage 1: difference vector.
  logic v1_r, v2_r, v3_r;
  logic signed [P-1:0]  a1_r [3], b1_r [3], a2_r [3], b2_r [3], a3_r [3], b3_r [3];
  logic signed [DW-1:0] d1_r [3], d2_r [3], d3_r [3];
  logic [MASS_W-1:0] wa1_r, wb1_r, wa2_r;
  logic [LIM_W-1:0]  lim1_r, lim2_r, lim3_r;

  // Stage 2: squares (capped for very wide positions) and mass sum.
  logic [D2_W-1:0] sq_nxt [3];
  logic [D2_W-1:0] sq2_r [3];
  logic [WRW-1:0]  wsum2_r, wsum3_r;

  for (genvar i = 0; i < 3; i++) begin : g_sq
    logic [DW-1:0]   ud;
    logic [2*DW-1:0] prod;
    assign ud   = d1_r[i][DW-1] ? DW'(-d1_r[i]) : DW'(d1_r[i]);
    assign prod = ud * ud;
    assign sq_nxt[i] = (64'(ud) >= 64'h8000_0000) ? D2_CAP : D2_W'(prod);
  end

  // Stage 3: sum with cap, first weight quotient bit.
  logic [63:0]     d2sum;
  logic [D2_W-1:0] dist2_nxt, dist2_3_r;
  logic            wq0_nxt, wq0_3_r, bothz_3_r;
  logic [WRW-1:0]  wrem0_nxt, wrem3_r;
  assign d2sum     = 64'(sq2_r[0]) + 64'(sq2_r[1]) + 64'(sq2_r[2]);
  assign dist2_nxt = (d2sum > 64'(D2_CAP)) ? D2_CAP : D2_W'(d2sum);
  assign wq0_nxt   = WRW'(wa2_r) >= wsum2_r;
  assign wrem0_nxt = WRW'(wa2_r) - (wq0_nxt ? wsum2_r : '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= start & ~busy;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      a1_r[i]  <= ain[i];
      b1_r[i]  <= bin[i];
      d1_r[i]  <= DW'(ain[i]) - DW'(bin[i]);
      a2_r[i]  <= a1_r[i];
      b2_r[i]  <= b1_r[i];
      d2_r[i]  <= d1_r[i];
      sq2_r[i] <= sq_nxt[i];
      a3_r[i]  <= a2_r[i];
      b3_r[i]  <= b2_r[i];
      d3_r[i]  <= d2_r[i];
    end
    wa1_r     <= in_inv_mass_a;
    wb1_r     <= in_inv_mass_b;
    lim1_r    <= in_max_len_sq;
    wa2_r     <= wa1_r;
    wsum2_r   <= WRW'(wa1_r) + WRW'(wb1_r);
    lim2_r    <= lim1_r;
    lim3_r    <= lim2_r;
    dist2_3_r <= dist2_nxt;
    wq0_3_r   <= wq0_nxt;
    wrem3_r   <= wrem0_nxt;
    wsum3_r   <= wsum2_r;
    bothz_3_r <= (wsum2_r == '0);
  end

  // Stage 4 feeds divider slot 0; slot k+1 holds the result of step k.
  ctl_t                 ctl_r  [NSTG+1];
  logic signed [P-1:0]  pa_r   [NSTG+1][3];
  logic signed [P-1:0]  pb_r   [NSTG+1][3];
  logic signed [DW-1:0] pd_r   [NSTG+1][3];
  logic [D2_W-1:0]      frem_r [NSTG+1];
  logic [D2_W-1:0]      fden_r [NSTG+1];
  logic [FACT_BITS-1:0] fq_r   [NSTG+1];
  logic [WRW-1:0]       wrem_r [NSTG+1];
  logic [WRW-1:0]       wsum_r [NSTG+1];
  logic [WGT_BITS:0]    wq_r   [NSTG+1];

  logic [D2_W-1:0] den_nxt;
  logic            apply_nxt;
  // Apply when at or beyond the limit and at least one particle can move.
  assign den_nxt   = dist2_3_r + D2_W'(lim3_r);
  assign apply_nxt = !(dist2_3_r < D2_W'(lim3_r)) && !bothz_3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r[0] <= '0;
    end else begin
      ctl_r[0] <= '{valid: v3_r, apply: apply_nxt, den_zero: (den_nxt == '0)};
    end
  end

  always_ff @(posedge clk) begin
    pa_r[0]   <= a3_r;
    pb_r[0]   <= b3_r;
    pd_r[0]   <= d3_r;
    frem_r[0] <= D2_W'(lim3_r);
    fden_r[0] <= den_nxt;
    fq_r[0]   <= '0;
    wrem_r[0] <= wrem3_r;
    wsum_r[0] <= wsum3_r;
    wq_r[0]   <= {{WGT_BITS{1'b0}}, wq0_3_r};
  end

  // Restoring dividers, one quotient bit per stage. The limit ratio needs
  // FACT_BITS steps and holds for the remaining slots; the mass weight
  // uses every slot.
  for (genvar k = 0; k < NSTG; k++) begin : g_div
    logic [D2_W:0]        fsh;
    logic [D2_W-1:0]      frem_nxt;
    logic [FACT_BITS-1:0] fq_nxt;
    logic [WRW:0]         wsh;
    logic [WRW-1:0]       wrem_nxt;
    logic [WGT_BITS:0]    wq_nxt;

    assign fsh = {frem_r[k], 1'b0};
    assign wsh = {wrem_r[k], 1'b0};

    always_comb begin
      if (k >= FACT_BITS) begin
        frem_nxt = frem_r[k];
        fq_nxt   = fq_r[k];
      end else if (fsh >= {1'b0, fden_r[k]}) begin
        frem_nxt = D2_W'(fsh - {1'b0, fden_r[k]});
        fq_nxt   = {fq_r[k][FACT_BITS-2:0], 1'b1};
      end else begin
        frem_nxt = D2_W'(fsh);
        fq_nxt   = {fq_r[k][FACT_BITS-2:0], 1'b0};
      end
      if (wsh >= {1'b0, wsum_r[k]}) begin
        wrem_nxt = WRW'(wsh - {1'b0, wsum_r[k]});
        wq_nxt   = {wq_r[k][WGT_BITS-1:0], 1'b1};
      end else begin
        wrem_nxt = WRW'(wsh);
        wq_nxt   = {wq_r[k][WGT_BITS-1:0], 1'b0};
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        ctl_r[k+1] <= '0;
      end else begin
        ctl_r[k+1] <= ctl_r[k];
      end
    end

    always_ff @(posedge clk) begin
      pa_r[k+1]   <= pa_r[k];
      pb_r[k+1]   <= pb_r[k];
      pd_r[k+1]   <= pd_r[k];
      frem_r[k+1] <= frem_nxt;
      fden_r[k+1] <= fden_r[k];
      fq_r[k+1]   <= fq_nxt;
      wrem_r[k+1] <= wrem_nxt;
      wsum_r[k+1] <= wsum_r[k];
      wq_r[k+1]   <= wq_nxt;
    end
  end

  // Per-axis correction, four stages each; axis x drives the strobe.
  res_t res_x;

  vmlc_axis #(.POS_WIDTH(P)) u_axis_x (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (ctl_r[NSTG]),
    .d     (pd_r[NSTG][0]),
    .a     (pa_r[NSTG][0]),
    .b     (pb_r[NSTG][0]),
    .q     (fq_r[NSTG]),
    .w_a   (wq_r[NSTG]),
    .res   (res_x),
    .new_a (out_new_a_x),
    .new_b (out_new_b_x)
  );

  vmlc_axis #(.POS_WIDTH(P)) u_axis_y (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (ctl_r[NSTG]),
    .d     (pd_r[NSTG][1]),
    .a     (pa_r[NSTG][1]),
    .b     (pb_r[NSTG][1]),
    .q     (fq_r[NSTG]),
    .w_a   (wq_r[NSTG]),
    .res   (),
    .new_a (out_new_a_y),
    .new_b (out_new_b_y)
  );

  vmlc_axis #(.POS_WIDTH(P)) u_axis_z (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (ctl_r[NSTG]),
    .d     (pd_r[NSTG][2]),
    .a     (pa_r[NSTG][2]),
    .b     (pb_r[NSTG][2]),
    .q     (fq_r[NSTG]),
    .w_a   (wq_r[NSTG]),
    .res   (),
    .new_a (out_new_a_z),
    .new_b (out_new_b_z)
  );

  assign out_valid   = res_x.valid;
  assign out_changed = res_x.changed;
endmodule
`default_nettype wire
